// ===== hw/rtl/bounded_ordered_list_engine_top_macros.svh =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine: assertion macros
// Shared property forms for the checker, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOLE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define BOLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

// ===== hw/rtl/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Sizes, command codes and the control word broadcast along the cell row.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);

  localparam logic [3:0] OP_INS_FRONT = 4'd0;
  localparam logic [3:0] OP_INS_BACK  = 4'd1;
  localparam logic [3:0] OP_INS_AT    = 4'd2;
  localparam logic [3:0] OP_REM_FRONT = 4'd3;
  localparam logic [3:0] OP_REM_BACK  = 4'd4;
  localparam logic [3:0] OP_REM_AT    = 4'd5;
  localparam logic [3:0] OP_SEARCH    = 4'd6;
  localparam logic [3:0] OP_SELECT    = 4'd7;
  localparam logic [3:0] OP_REPLACE   = 4'd8;

  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_INS  = 2'd1;
  localparam logic [1:0] MODE_REM  = 2'd2;
  localparam logic [1:0] MODE_WR   = 2'd3;

  typedef struct packed {
    logic                  step;
    logic [1:0]            mode;
    logic [COUNT_W-1:0]    idx;
    logic [COUNT_W-1:0]    cnt;
    logic [VALUE_BITS-1:0] value;
  } bole_ctrl_t;

endpackage

// ===== hw/rtl/bole_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine: list cell
// Holds one list entry, shifts with its neighbors and matches a search key.
// ----------------------------------------------------------------------------
module bole_cell
  import bole_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      cell_index,
  input  bole_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic [VALUE_BITS-1:0] right_value,
  output logic [VALUE_BITS-1:0] value,
  output logic                  match
);

  logic [COUNT_W-1:0]    my_index;
  logic [VALUE_BITS-1:0] value_next;

  assign my_index = COUNT_W'(cell_index);

  // Only cells inside the list take part in a search.
  assign match = (value == ctrl.value) && (my_index < ctrl.cnt);

  always_comb begin
    value_next = value;
    case (ctrl.mode)
      MODE_INS: begin
        if (my_index > ctrl.idx) begin
          value_next = left_value;
        end else if (my_index == ctrl.idx) begin
          value_next = ctrl.value;
        end
      end
      MODE_REM: begin
        if (my_index >= ctrl.idx) begin
          value_next = right_value;
        end
      end
      MODE_WR: begin
        if (my_index == ctrl.idx) begin
          value_next = ctrl.value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      value <= value_next;
    end
  end

endmodule

// ===== hw/rtl/bounded_ordered_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered list of up to CAPACITY values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Each command word is registered at acceptance; in its execute cycle the
// whole cell row shifts, writes or compares at once while the result is
// loaded into the output register. in_stall stays high through the execute
// cycle, and longer if the output register is still holding an untaken
// result, so one command is in flight at a time; a new word is taken while
// a finished result waits on out_stall.
module bounded_ordered_list_engine_top
  import bole_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            op,
  input  logic [4:0]            position,
  input  logic [31:0]           item_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  ok,
  output logic [4:0]            found_index,
  output logic [31:0]           read_value,
  output logic [4:0]            count,
  output logic                  is_empty,
  output logic                  is_full
);

  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  logic                  busy;
  logic [3:0]            cmd_op;
  logic [4:0]            cmd_pos;
  logic [VALUE_BITS-1:0] cmd_val;
  logic [COUNT_W-1:0]    entry_count;
  logic [COUNT_W-1:0]    entry_count_next;

  logic                  exec;
  bole_ctrl_t            ctrl;
  logic [COUNT_W-1:0]    pos_ext;
  logic [COUNT_W-1:0]    eidx;
  logic                  ins_ok;
  logic                  rem_ok;
  logic                  res_ok;
  logic [COUNT_W-1:0]    res_found;
  logic [VALUE_BITS-1:0] res_read;
  logic [COUNT_W-1:0]    search_hit;
  logic [IDX_W-1:0]      read_index;

  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;

  assign in_stall = busy;
  assign exec     = busy && (!out_valid || !out_stall);
  assign pos_ext  = COUNT_W'(cmd_pos);

  always_comb begin
    eidx = '0;
    case (cmd_op)
      OP_INS_BACK: eidx = entry_count;
      OP_REM_BACK: eidx = entry_count - COUNT_W'(1);
      OP_INS_AT, OP_REM_AT, OP_REPLACE: eidx = pos_ext;
      default: eidx = '0;
    endcase
  end

  assign ins_ok = (entry_count < CAP_COUNT) && (eidx <= entry_count);
  assign rem_ok = (entry_count != '0) && (eidx < entry_count);

  // Search result: lowest matching cell, or the count when nothing matches.
  always_comb begin
    search_hit = entry_count;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        search_hit = COUNT_W'(i);
      end
    end
  end

  // Select past the end reads the last entry.
  assign read_index = (pos_ext < entry_count) ? cmd_pos[IDX_W-1:0]
                                              : IDX_W'(entry_count - COUNT_W'(1));

  always_comb begin
    ctrl             = '0;
    ctrl.step        = exec;
    ctrl.idx         = eidx;
    ctrl.cnt         = entry_count;
    ctrl.value       = cmd_val;
    ctrl.mode        = MODE_HOLD;
    entry_count_next = entry_count;
    res_ok           = 1'b0;
    res_found        = '0;
    res_read         = '0;
    case (cmd_op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (ins_ok) begin
          ctrl.mode        = MODE_INS;
          entry_count_next = entry_count + COUNT_W'(1);
          res_ok           = 1'b1;
        end
      end
      OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
        if (rem_ok) begin
          ctrl.mode        = MODE_REM;
          entry_count_next = entry_count - COUNT_W'(1);
          res_ok           = 1'b1;
        end
      end
      OP_SEARCH: begin
        res_ok    = 1'b1;
        res_found = search_hit;
      end
      OP_SELECT: begin
        if (entry_count != '0) begin
          res_ok   = 1'b1;
          res_read = cell_value[read_index];
        end
      end
      OP_REPLACE: begin
        if (pos_ext < entry_count) begin
          ctrl.mode = MODE_WR;
          res_ok    = 1'b1;
        end
      end
      default: res_ok = 1'b0;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v;
    logic [VALUE_BITS-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[g+1];
    end

    bole_cell u_cell (
      .clk         (clk),
      .cell_index  (IDX_W'(g)),
      .ctrl        (ctrl),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[g]),
      .match       (cell_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      entry_count <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        busy <= 1'b1;
      end else if (exec) begin
        busy <= 1'b0;
      end
      if (exec) begin
        out_valid   <= 1'b1;
        entry_count <= entry_count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_op  <= op;
      cmd_pos <= position;
      cmd_val <= item_value[VALUE_BITS-1:0];
    end
    if (exec) begin
      ok          <= res_ok;
      found_index <= 5'(res_found);
      read_value  <= 32'(res_read);
      count       <= 5'(entry_count_next);
      is_empty    <= (entry_count_next == '0);
      is_full     <= (entry_count_next == CAP_COUNT);
    end
  end

endmodule

// ===== hw/rtl/bole_checker.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine: port checker
// Watches the top level's ports and checks result flags and flow control.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_engine_top_macros.svh"

module bole_checker
  import bole_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        ok,
  input logic [4:0]  found_index,
  input logic [31:0] read_value,
  input logic [4:0]  count,
  input logic        is_empty,
  input logic        is_full
);

  // A word that waits on out_stall must not change under the consumer.
  `BOLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_value) && $stable(count))

  // The empty flag agrees with the reported count.
  `BOLE_ASSERT_SAME(a_empty_flag, out_valid, is_empty == (count == 5'd0))

  // The full flag agrees with the count, which never exceeds capacity.
  `BOLE_ASSERT_SAME(a_full_flag, out_valid, (is_full == (count == 5'(CAPACITY))) && (count <= 5'(CAPACITY)))

  // A refused command reports neither a search index nor a read value.
  `BOLE_ASSERT_SAME(a_refused_zero, out_valid && !ok, (found_index == 5'd0) && (read_value == 32'd0))

  // One command at a time: after a word is taken the input is stalled.
  `BOLE_ASSERT_NEXT(a_one_cmd, in_valid && !in_stall, in_stall)

endmodule

bind bounded_ordered_list_engine_top bole_checker u_bole_checker (.*);

// ===== tb/bounded_ordered_list_engine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list engine: result checker
// Watches both channels of the list engine. Each accepted command word is run
// through a local model of the list, and each accepted result word is checked
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_checker
  import bole_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  op,
  input  logic [4:0]  position,
  input  logic [31:0] item_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        ok,
  input  logic [4:0]  found_index,
  input  logic [31:0] read_value,
  input  logic [4:0]  count,
  input  logic        is_empty,
  input  logic        is_full,
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          full_count
);

  typedef struct packed {
    logic        ok;
    logic [4:0]  found_index;
    logic [31:0] read_value;
    logic [4:0]  count;
    logic        is_empty;
    logic        is_full;
  } list_result_t;

  logic [VALUE_BITS-1:0] list_values [CAPACITY];
  int                    list_len;
  list_result_t          expected_results [$];
  int                    fail_tally;
  int                    checked_tally;
  int                    full_tally;

  initial begin
    list_len      = 0;
    fail_tally    = 0;
    checked_tally = 0;
    full_tally    = 0;
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    full_count    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_tally++;
  endtask

  // Applies one command to the local list and returns the result word it yields.
  task automatic apply_list_command(input logic [3:0] cmd, input logic [4:0] pos,
                                    input logic [31:0] val, output list_result_t res);
    int  idx;
    bit  hit;
    res = '0;
    case (cmd)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        idx = (cmd == OP_INS_FRONT) ? 0 : (cmd == OP_INS_BACK) ? list_len : int'(pos);
        if (list_len < CAPACITY && idx <= list_len) begin
          for (int k = list_len; k > idx; k--) list_values[k] = list_values[k-1];
          list_values[idx] = val;
          list_len++;
          res.ok = 1'b1;
        end
      end
      OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
        idx = (cmd == OP_REM_FRONT) ? 0 : (cmd == OP_REM_BACK) ? list_len - 1 : int'(pos);
        if (list_len != 0 && idx >= 0 && idx < list_len) begin
          for (int k = idx; k + 1 < list_len; k++) list_values[k] = list_values[k+1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        // An absent value reports the count, which is zero on an empty list.
        res.ok = 1'b1;
        res.found_index = 5'(list_len);
        hit = 1'b0;
        for (int k = 0; k < list_len; k++) begin
          if (!hit && list_values[k] == val) begin
            res.found_index = 5'(k);
            hit = 1'b1;
          end
        end
      end
      OP_SELECT: begin
        // An index past the end reads the last entry instead of failing.
        if (list_len != 0) begin
          res.ok = 1'b1;
          res.read_value = list_values[(int'(pos) < list_len) ? int'(pos) : list_len - 1];
        end
      end
      OP_REPLACE: begin
        if (int'(pos) < list_len) begin
          list_values[pos] = val;
          res.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.count    = 5'(list_len);
    res.is_empty = (list_len == 0);
    res.is_full  = (list_len == CAPACITY);
  endtask

  always @(posedge clk) begin : watch_channels
    list_result_t want;
    list_result_t fresh;
    if (rst) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked_tally++;
        if (is_full) full_tally++;
        if (expected_results.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (ok !== want.ok)
            report_mismatch($sformatf("ok got %0b expected %0b", ok, want.ok));
          if (found_index !== want.found_index)
            report_mismatch($sformatf("found_index got %0d expected %0d",
                                      found_index, want.found_index));
          if (read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %08h expected %08h",
                                      read_value, want.read_value));
          if (count !== want.count)
            report_mismatch($sformatf("count got %0d expected %0d", count, want.count));
          if (is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %0b expected %0b",
                                      is_empty, want.is_empty));
          if (is_full !== want.is_full)
            report_mismatch($sformatf("is_full got %0b expected %0b", is_full, want.is_full));
        end
      end
      if (in_valid && !in_stall) begin
        apply_list_command(op, position, item_value, fresh);
        expected_results.push_back(fresh);
      end
    end
    pending       <= expected_results.size();
    fail_count    <= fail_tally;
    checked_count <= checked_tally;
    full_count    <= full_tally;
  end

endmodule

// ===== tb/bounded_ordered_list_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list engine testbench
// Drives list commands into the engine: a directed pass over empty-list,
// out-of-range and boundary cases, then random fill, drain and mixed phases
// with bursty idling on both channels. A separate checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top_tb;
  import bole_pkg::*;

  localparam int RANDOM_WORDS = 1930;
  localparam int CALM_WORDS   = 200;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE       = 8;

  typedef enum {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} traffic_phase_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  op = OP_SEARCH;
  logic [4:0]  position = '0;
  logic [31:0] item_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        ok;
  logic [4:0]  found_index;
  logic [31:0] read_value;
  logic [4:0]  count;
  logic        is_empty;
  logic        is_full;

  int fail_count;
  int pending;
  int checked_count;
  int full_count;
  int words_sent = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;
  bit calm = 1'b0;

  bounded_ordered_list_engine_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .position(position), .item_value(item_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .found_index(found_index), .read_value(read_value),
    .count(count), .is_empty(is_empty), .is_full(is_full)
  );

  bounded_ordered_list_engine_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .position(position), .item_value(item_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .found_index(found_index), .read_value(read_value),
    .count(count), .is_empty(is_empty), .is_full(is_full),
    .fail_count(fail_count), .pending(pending),
    .checked_count(checked_count), .full_count(full_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one command word and returns once it is taken, at times after a random idle gap on the input.
  task automatic issue_command(input logic [3:0] cmd, input logic [4:0] pos,
                               input logic [31:0] val);
    in_valid   <= 1'b1;
    op         <= cmd;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // The pending count is registered, so it is read only once its register has caught up.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_command(input traffic_phase_t phase);
    int r;
    int ins_share;
    int rem_share;
    r = $urandom_range(0, 99);
    ins_share = (phase == FILL_PHASE) ? 65 : (phase == DRAIN_PHASE) ? 15 : 35;
    rem_share = (phase == FILL_PHASE) ? 10 : (phase == DRAIN_PHASE) ? 60 : 35;
    if (r == 0) return 4'($urandom_range(int'(OP_REPLACE) + 1, 15));
    if (r <= ins_share) begin
      case ($urandom_range(0, 2))
        0:       return OP_INS_FRONT;
        1:       return OP_INS_BACK;
        default: return OP_INS_AT;
      endcase
    end
    if (r <= ins_share + rem_share) begin
      case ($urandom_range(0, 2))
        0:       return OP_REM_FRONT;
        1:       return OP_REM_BACK;
        default: return OP_REM_AT;
      endcase
    end
    case ($urandom_range(0, 2))
      0:       return OP_SEARCH;
      1:       return OP_SELECT;
      default: return OP_REPLACE;
    endcase
  endfunction

  function automatic logic [4:0] pick_position();
    if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 4));
    return 5'($urandom_range(0, CAPACITY));
  endfunction

  // Small values recur often so that searches find earlier inserts.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($urandom_range(0, 7));
    if (r == 5) return 32'h0000_0000;
    if (r == 6) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // Output side: random stall bursts, plus one long hold on request.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    traffic_phase_t phase;
    phase = MIXED_PHASE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every refusal on an empty list, a search on it, and an unused command code.
    issue_command(OP_SELECT, 5'd0, 32'h0);
    issue_command(OP_SEARCH, 5'd0, 32'h0);
    issue_command(OP_REM_FRONT, 5'd0, 32'h0);
    issue_command(OP_REM_BACK, 5'd0, 32'h0);
    issue_command(OP_REM_AT, 5'd0, 32'h0);
    issue_command(OP_REPLACE, 5'd0, 32'h1234_5678);
    issue_command(4'hF, 5'd31, 32'hFFFF_FFFF);
    // Build a short list, then search, select, replace and remove on it; an insert index equal to the count appends.
    issue_command(OP_INS_BACK, 5'd0, 32'h0000_0000);
    issue_command(OP_INS_FRONT, 5'd0, 32'hFFFF_FFFF);
    issue_command(OP_INS_AT, 5'd2, 32'h5A5A_5A5A);
    issue_command(OP_INS_AT, 5'd4, 32'h1111_1111);
    issue_command(OP_SEARCH, 5'd0, 32'hFFFF_FFFF);
    issue_command(OP_SEARCH, 5'd0, 32'hDEAD_BEEF);
    issue_command(OP_SELECT, 5'd16, 32'h0);
    issue_command(OP_SELECT, 5'd1, 32'h0);
    issue_command(OP_REPLACE, 5'd3, 32'h2222_2222);
    issue_command(OP_REPLACE, 5'd2, 32'hA5A5_A5A5);
    issue_command(OP_REM_AT, 5'd1, 32'h0);
    issue_command(OP_REM_AT, 5'd2, 32'h0);
    issue_command(OP_REM_BACK, 5'd0, 32'h0);
    issue_command(OP_REM_FRONT, 5'd0, 32'h0);
    issue_command(OP_SELECT, 5'd16, 32'h0);
    wait_for_results();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) phase = traffic_phase_t'($urandom_range(0, 2));
      // The receiver holds off while words keep coming, so the engine backs up.
      if (n == 600) hold_request = 1'b1;
      if (n == 1200) wait_for_results();
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      issue_command(pick_command(phase), pick_position(), pick_value());
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    $display("Summary: %0d command words sent, %0d result words checked, %0d with the list full.",
             words_sent, checked_count, full_count);
    $display("Fill, drain and mixed phases ran with bursty stalls, a long output hold and a drain.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bole_pkg.sv
hw/rtl/bole_cell.sv
hw/rtl/bounded_ordered_list_engine_top.sv
hw/rtl/bole_checker.sv
tb/bounded_ordered_list_engine_checker.sv
tb/bounded_ordered_list_engine_top_tb.sv
